// ===== hw/rtl/pls_pkg.sv =====
// Shared types and constants for the positional list store.
`default_nettype none
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // wide enough to compare a position against count + 1 without overflow
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DEL_LAST = 3'd2,
    OP_DEL_POS  = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_cmd_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    cell_cmd_t               cmd;
    logic [CNT_W-1:0]        k;      // 0-based target slot
    logic [CNT_W-1:0]        count;  // entries before the operation
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pls_cell.sv =====
// One storage cell of the list chain.
`default_nettype none
module pls_cell
  import pls_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic [IDX_W-1:0]         cell_idx,
  input  wire logic signed [DATA_W-1:0] left_val,
  input  wire logic signed [DATA_W-1:0] right_val,
  input  wire logic signed [DATA_W-1:0] head_val,
  output logic signed [DATA_W-1:0]      val
);

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]         idx;
  logic [CNT_W-1:0]         idx_p1;

  assign idx    = CNT_W'(cell_idx);
  assign idx_p1 = idx + CNT_W'(1);

  always_comb begin
    val_nxt = val_r;
    case (ctrl.cmd)
      CELL_INS: begin
        if (idx > ctrl.k) val_nxt = left_val;
        else if (idx == ctrl.k) val_nxt = ctrl.value;
      end
      CELL_DEL: begin
        if (idx >= ctrl.k) val_nxt = right_val;
      end
      CELL_ROT: begin
        // rotate the occupied part toward the head; tail takes the old head
        if (idx_p1 == ctrl.count) val_nxt = head_val;
        else if (idx_p1 < ctrl.count) val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

// ===== hw/rtl/positional_list_store.sv =====
// Top level of the positional list store: control and cell chain.
// Positional list store: an ordered list of up to CAPACITY signed 32-bit
// values held in a chain of cells that shift together.
// Input channel (in_valid/in_ready) carries opcode, item_value, position.
// Result channel (out_valid/out_ready) carries status, read_value,
// entry_count, is_readout and last_result.
// Append, insert, delete and bad requests give one result each, registered,
// in the cycle after acceptance. A new item is taken when no read out is
// in progress and the output register is empty or being drained.
// Read out of n entries: one entry per cycle while the receiver takes them,
// as the chain rotates its occupied cells past the head; after n results
// the list is back in order and the block takes items again.
// An empty read out gives a single result with status list empty.
// If the receiver stalls, the output register holds its result and no
// item is taken and no cell moves until it is drained.
// Reset empties the list (count zero); cell contents are left as they are.
`default_nettype none
module positional_list_store
  import pls_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_opcode,
  input  wire logic signed [31:0] in_item_value,
  input  wire logic [7:0]         in_position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_read_value,
  output logic [4:0]              out_entry_count,
  output logic                    out_is_readout,
  output logic                    out_last_result
);

  logic                     busy_r, busy_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  status_r, status_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     readout_r, readout_nxt;
  logic                     last_r, last_nxt;

  logic                     slot_free;
  logic                     acc;
  logic [CMP_W-1:0]         pos_w;
  logic [CMP_W-1:0]         cnt_w;
  logic                     full;
  logic                     empty;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] vals [CAPACITY];

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !busy_r && slot_free;
  assign acc       = in_valid && in_ready;
  assign pos_w     = CMP_W'(in_position);
  assign cnt_w     = CMP_W'(count_r);
  assign full      = (cnt_w == CMP_W'(CAPACITY));
  assign empty     = (count_r == '0);

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    value_nxt     = value_r;
    readout_nxt   = readout_r;
    last_nxt      = last_r;
    ctrl.cmd      = CELL_HOLD;
    ctrl.k        = count_r;
    ctrl.count    = count_r;
    ctrl.value    = in_item_value;

    if (busy_r) begin
      if (slot_free) begin
        ctrl.cmd      = CELL_ROT;
        out_valid_nxt = 1'b1;
        status_nxt    = ST_OK;
        value_nxt     = vals[0];
        readout_nxt   = 1'b1;
        last_nxt      = (rd_cnt_r + CNT_W'(1) == count_r);
        rd_cnt_nxt    = rd_cnt_r + CNT_W'(1);
        if (rd_cnt_r + CNT_W'(1) == count_r) busy_nxt = 1'b0;
      end
    end else if (acc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      value_nxt     = '0;
      readout_nxt   = 1'b0;
      last_nxt      = 1'b1;
      case (in_opcode)
        OP_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.cmd  = CELL_INS;
            ctrl.k    = count_r;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
            status_nxt = ST_RANGE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.cmd  = CELL_INS;
            ctrl.k    = CNT_W'(pos_w - CMP_W'(1));
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_DEL_LAST: begin
          if (empty) status_nxt = ST_EMPTY;
          else count_nxt = count_r - CNT_W'(1);
        end
        OP_DEL_POS: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else if (pos_w == '0 || pos_w > cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            ctrl.cmd  = CELL_DEL;
            ctrl.k    = CNT_W'(pos_w - CMP_W'(1));
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_READ: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            // results come from the rotation cycles that follow
            out_valid_nxt = 1'b0;
            busy_nxt      = 1'b1;
            rd_cnt_nxt    = '0;
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r  <= status_nxt;
    value_r   <= value_nxt;
    readout_r <= readout_nxt;
    last_r    <= last_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end
    pls_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (vals[0]),
      .val       (vals[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = value_r;
  assign out_entry_count = 5'(count_r);
  assign out_is_readout  = readout_r;
  assign out_last_result = last_r;

endmodule
`default_nettype wire

// ===== tb/positional_list_store_tb.sv =====
// Self-checking testbench for the positional list store: random and directed items.
`default_nettype none
module positional_list_store_tb
  import pls_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 104;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} mode_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [7:0]         pos;
  } list_cmd_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] value;
    logic [4:0]         count;
    logic               readout;
    logic               last;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_opcode = '0;
  logic signed [31:0] in_item_value = '0;
  logic [7:0]         in_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_read_value;
  logic [4:0]         out_entry_count;
  logic               out_is_readout;
  logic               out_last_result;

  list_cmd_t          pending_cmds[$];
  list_result_t       expected_results[$];
  logic signed [31:0] list_vals[$];   // predicted list contents, head first
  int                 gen_count = 0;  // count as the generator sees it
  int                 error_count = 0;
  int                 idle_cycles = 0;
  int                 in_gap = 0;
  int                 in_calm = 0;
  int                 out_gap = 0;
  int                 out_calm = 0;

  positional_list_store uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_item_value  (in_item_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_entry_count(out_entry_count),
    .out_is_readout (out_is_readout),
    .out_last_result(out_last_result)
  );

  always #2 clk = ~clk;

  function automatic void push_result(status_t st, logic signed [31:0] value,
                                      logic readout, logic last);
    list_result_t r;
    r.status  = st;
    r.value   = value;
    r.count   = 5'(list_vals.size());
    r.readout = readout;
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_results(list_cmd_t c);
    status_t st;
    int      n;
    st = ST_OK;
    n  = list_vals.size();
    case (c.op)
      OP_APPEND: begin
        if (n >= CAPACITY) st = ST_FULL;
        else list_vals.push_back(c.value);
      end
      OP_INSERT: begin
        // range check wins over full
        if (c.pos == 0 || int'(c.pos) > n + 1) st = ST_RANGE;
        else if (n >= CAPACITY) st = ST_FULL;
        else list_vals.insert(int'(c.pos) - 1, c.value);
      end
      OP_DEL_LAST: begin
        if (n == 0) st = ST_EMPTY;
        else void'(list_vals.pop_back());
      end
      OP_DEL_POS: begin
        if (n == 0) st = ST_EMPTY;
        else if (c.pos == 0 || int'(c.pos) > n) st = ST_RANGE;
        else list_vals.delete(int'(c.pos) - 1);
      end
      OP_READ: begin
        if (n == 0) begin
          push_result(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            push_result(ST_OK, list_vals[i], 1'b1, i == n - 1);
        end
        return;
      end
      default: ;
    endcase
    push_result(st, '0, 1'b0, 1'b1);
  endfunction

  // mostly short gaps, a few long ones, none during a calm stretch
  function automatic int pick_gap(int calm);
    int r;
    if (calm > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_calm();
    return ($urandom_range(0, 99) < 3) ? $urandom_range(20, 60) : 0;
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return VAL_MIN;
    if (r < 16) return VAL_MAX;
    if (r < 20) return '0;
    return $urandom();
  endfunction

  task automatic queue_item(logic [2:0] op, logic signed [31:0] value, logic [7:0] pos);
    list_cmd_t c;
    c.op    = op;
    c.value = value;
    c.pos   = pos;
    pending_cmds.push_back(c);
    case (op)
      OP_APPEND:   if (gen_count < CAPACITY) gen_count++;
      OP_INSERT:   if (pos != 0 && int'(pos) <= gen_count + 1 && gen_count < CAPACITY)
                     gen_count++;
      OP_DEL_LAST: if (gen_count > 0) gen_count--;
      OP_DEL_POS:  if (gen_count > 0 && pos != 0 && int'(pos) <= gen_count) gen_count--;
      default: ;
    endcase
  endtask

  task automatic queue_random(mode_t mode);
    int r;
    int hi;
    r  = $urandom_range(0, 99);
    hi = (gen_count > 0) ? gen_count : 1;
    if (r >= 92) begin
      // noise: any opcode, any position
      queue_item(3'($urandom_range(0, 7)), $urandom(), 8'($urandom_range(0, 255)));
      return;
    end
    case (mode)
      MODE_GROW: begin
        if (r < 45) queue_item(OP_APPEND, pick_value(), 8'($urandom()));
        else if (r < 84) queue_item(OP_INSERT, pick_value(),
                                    8'($urandom_range(1, gen_count + 1)));
        else queue_item(OP_READ, $urandom(), 8'($urandom()));
      end
      MODE_SHRINK: begin
        if (r < 35) queue_item(OP_DEL_LAST, $urandom(), 8'($urandom()));
        else if (r < 80) queue_item(OP_DEL_POS, $urandom(), 8'($urandom_range(1, hi)));
        else queue_item(OP_READ, $urandom(), 8'($urandom()));
      end
      default: begin
        if (r < 18) queue_item(OP_APPEND, pick_value(), 8'($urandom()));
        else if (r < 40) queue_item(OP_INSERT, pick_value(),
                                    8'($urandom_range(0, gen_count + 2)));
        else if (r < 55) queue_item(OP_DEL_LAST, $urandom(), 8'($urandom()));
        else if (r < 77) queue_item(OP_DEL_POS, $urandom(),
                                    8'($urandom_range(0, gen_count + 1)));
        else queue_item(OP_READ, $urandom(), 8'($urandom()));
      end
    endcase
  endtask

  // driver: one item at a time from pending_cmds
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        list_cmd_t acc;
        acc.op    = in_opcode;
        acc.value = in_item_value;
        acc.pos   = in_position;
        predict_results(acc);
      end
      if (!in_valid || in_ready) begin
        if (in_calm > 0) in_calm = in_calm - 1;
        else in_calm = pick_calm();
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          list_cmd_t nxt;
          nxt = pending_cmds.pop_front();
          in_opcode     <= nxt.op;
          in_item_value <= nxt.value;
          in_position   <= nxt.pos;
          in_valid      <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d value=%0d count=%0d readout=%0b last=%0b",
                   $time, out_status, out_read_value, out_entry_count, out_is_readout,
                   out_last_result);
          error_count++;
        end else begin
          list_result_t e;
          e = expected_results.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            error_count++;
          end
          if (out_read_value !== e.value) begin
            $display("%0t: read_value expected %0d actual %0d", $time, e.value,
                     out_read_value);
            error_count++;
          end
          if (out_entry_count !== e.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, e.count,
                     out_entry_count);
            error_count++;
          end
          if (out_is_readout !== e.readout) begin
            $display("%0t: is_readout expected %0b actual %0b", $time, e.readout,
                     out_is_readout);
            error_count++;
          end
          if (out_last_result !== e.last) begin
            $display("%0t: last_result expected %0b actual %0b", $time, e.last,
                     out_last_result);
            error_count++;
          end
        end
      end
      if (out_calm > 0) out_calm = out_calm - 1;
      else out_calm = pick_calm();
      if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap(out_calm);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    mode_t mode;
    int    seg_len;
    int    rand_added;

    // directed: empty cases, bad positions, head/middle/tail edits, spare opcodes
    queue_item(OP_READ, '0, '0);
    queue_item(OP_DEL_LAST, '0, '0);
    queue_item(OP_DEL_POS, '0, 8'd1);
    queue_item(OP_INSERT, 32'sh0000_1234, 8'd0);
    queue_item(OP_INSERT, 32'sh0000_1234, 8'd2);
    queue_item(OP_INSERT, VAL_MIN, 8'd1);
    queue_item(OP_APPEND, VAL_MAX, '0);
    queue_item(OP_APPEND, -32'sd1, 8'hff);
    queue_item(OP_INSERT, 32'sh5555_5555, 8'd4);
    queue_item(OP_INSERT, 32'shaaaa_aaaa, 8'd2);
    queue_item(OP_INSERT, 32'sd7, 8'd7);
    queue_item(OP_INSERT, 32'sd7, 8'hff);
    queue_item(OP_READ, '0, '0);
    queue_item(OP_DEL_POS, '0, 8'd0);
    queue_item(OP_DEL_POS, '0, 8'd6);
    queue_item(OP_DEL_POS, '0, 8'hff);
    queue_item(OP_DEL_POS, '0, 8'd1);
    queue_item(OP_DEL_POS, '0, 8'd4);
    queue_item(OP_APPEND, 32'sh0f0f_0f0f, '0);
    queue_item(OP_DEL_LAST, '0, '0);
    queue_item(OP_READ, '0, '0);
    queue_item(OP_SPARE5, '0, '0);
    queue_item(OP_SPARE6, -32'sd1, 8'hff);
    queue_item(OP_SPARE7, 32'sd1, 8'd1);

    // random segments; the first one fills the list up to and past full
    rand_added = 0;
    mode = MODE_GROW;
    seg_len = 26;
    while (rand_added < RANDOM_ITEMS) begin
      for (int i = 0; i < seg_len && rand_added < RANDOM_ITEMS; i++) begin
        queue_random(mode);
        if (pending_cmds[$].op <= OP_READ) rand_added++;
      end
      mode = mode_t'($urandom_range(0, 2));
      seg_len = $urandom_range(8, 24);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
